// File: rtl/core/pctb_pkg.sv
`default_nettype none

package pctb_pkg;

  // bucket table depth, client index wraps modulo this
  localparam int NUM_CLIENTS = 256;
  localparam int CLIENT_W    = $clog2(NUM_CLIENTS);

  // field widths
  localparam int CLIENT_IN_W = 8;
  localparam int TICK_W      = 32;
  localparam int COST_W      = 16;
  localparam int Q_W         = 32;
  localparam int FRAC_W      = 16;
  localparam int TOKENS_W    = 16;

  // bucket entry: level in the low half, last time in the high half
  localparam int ENTRY_W = Q_W + TICK_W;

  // stream payload widths (whole bytes)
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY = CFG_IDX_W'(1);

  localparam logic [Q_W-1:0] REFILL_RATE_RST     = 32'd65536;
  localparam logic [Q_W-1:0] BUCKET_CAPACITY_RST = 32'd655360;

  typedef struct packed {
    logic [Q_W-1:0] refill_rate;
    logic [Q_W-1:0] bucket_capacity;
  } pctb_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/pctb_ram.sv
`default_nettype none

module pctb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/pctb_engine.sv
`default_nettype none

module pctb_engine
  import pctb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pctb_cfg_t              cfg,
  input  wire logic                   req_valid,
  output logic                        req_ready,
  input  wire logic [CLIENT_IN_W-1:0] req_client,
  input  wire logic [TICK_W-1:0]      req_now,
  input  wire logic [COST_W-1:0]      req_cost,
  output logic                        rsp_valid,
  input  wire logic                   rsp_ready,
  output logic                        rsp_allowed,
  output logic [TOKENS_W-1:0]         rsp_tokens
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_ADD,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [NUM_CLIENTS-1:0] valid_r;
  logic [CLIENT_W-1:0]    idx_r;
  logic [TICK_W-1:0]      now_r;
  logic [COST_W-1:0]      cost_r;
  logic                   hit_r;
  logic [Q_W-1:0]         level_r;
  logic [TICK_W-1:0]      elapsed_r;
  logic [2*Q_W-1:0]       prod_r;
  logic [Q_W-1:0]         clip_r;
  logic                   rsp_valid_r;
  logic                   rsp_allowed_r;
  logic [TOKENS_W-1:0]    rsp_tokens_r;

  logic [ENTRY_W-1:0]     rd_entry;
  logic [CLIENT_W-1:0]    rd_addr;
  logic                   wr_en;
  logic [2*Q_W-1:0]       prod_c;
  logic [2*Q_W-1:0]       sum_c;
  logic [Q_W-1:0]         need_c;
  logic                   ok_c;
  logic [Q_W-1:0]         new_level_c;
  logic                   rsp_free;

  assign rd_addr  = req_client[CLIENT_W-1:0];
  assign rsp_free = !rsp_valid_r || rsp_ready;
  assign wr_en    = (state_r == S_DONE) && rsp_free;

  pctb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CLIENTS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_r),
    .wdata ({now_r, new_level_c}),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  // refill, clip and debit
  assign prod_c      = elapsed_r * cfg.refill_rate;
  assign sum_c       = {{Q_W{1'b0}}, level_r} + prod_r;
  assign need_c      = {cost_r, {FRAC_W{1'b0}}};
  assign ok_c        = clip_r >= need_c;
  assign new_level_c = ok_c ? (clip_r - need_c) : clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      rsp_valid_r <= 1'b0;
    end else begin
      // output register: loaded on completion, emptied when taken
      if (wr_en) begin
        rsp_valid_r <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            idx_r   <= rd_addr;
            now_r   <= req_now;
            cost_r  <= req_cost;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          hit_r     <= valid_r[idx_r];
          level_r   <= rd_entry[Q_W-1:0];
          elapsed_r <= now_r - rd_entry[ENTRY_W-1:Q_W];
          state_r   <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= prod_c;
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (!hit_r || (sum_c > {{Q_W{1'b0}}, cfg.bucket_capacity})) begin
            clip_r <= cfg.bucket_capacity;
          end else begin
            clip_r <= sum_c[Q_W-1:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            valid_r[idx_r] <= 1'b1;
            rsp_allowed_r  <= ok_c;
            rsp_tokens_r   <= new_level_c[Q_W-1:FRAC_W];
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready   = (state_r == S_IDLE);
  assign rsp_valid   = rsp_valid_r;
  assign rsp_allowed = rsp_allowed_r;
  assign rsp_tokens  = rsp_tokens_r;

`ifndef SYNTHESIS
  // a result only appears as a request completes
  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rsp_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  // a written bucket is marked valid afterwards
  a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(idx_r)])
    else $error("bucket not marked valid after write");

  // level left never exceeds capacity
  a_tokens_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (new_level_c <= cfg.bucket_capacity))
    else $error("bucket level above capacity");

  // one request at a time
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while busy");
`endif

endmodule

`default_nettype wire

// File: rtl/core/per_client_token_bucket_unit.sv
`default_nettype none

// per-client token bucket policer
// in_*  : request beats, tdata = {cost[15:0], now_ticks[31:0], client[7:0]}
// out_* : verdict beats, tdata = {7'b0, tokens_left[15:0], allowed}
// cfg_* : register writes, index 0 refill_rate, index 1 bucket_capacity
//         (both unsigned q16.16); other indexes are ignored
// each request reads its bucket from a one-port-read, one-port-write ram,
// refills it by elapsed ticks times refill_rate, clips at capacity and
// debits the cost if enough tokens are there
// an accepted in beat passes the read, multiply, add and done states and
// then the output register that drives out_tvalid; a request is taken
// only after the last has done the bucket ram read-modify-write (read,
// subtract, multiply, add and clip, debit and write), even while its
// verdict still waits in the output register; on a receiver stall the
// next request holds in its final stage until the output register frees
// reset clears all bucket valid bits, so every client starts with a full
// bucket; rates return to 1.0 token per tick and capacity to 10.0 tokens
module per_client_token_bucket_unit
  import pctb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // lowest bit up: client[7:0], now_ticks[31:0], cost[15:0]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // lowest bit up: allowed, tokens_left[15:0], zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  pctb_cfg_t           cfg_r;
  logic [CLIENT_IN_W-1:0] in_client;
  logic [TICK_W-1:0]   in_now;
  logic [COST_W-1:0]   in_cost;
  logic                out_allowed;
  logic [TOKENS_W-1:0] out_tokens;

  // configuration writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.refill_rate     <= REFILL_RATE_RST;
      cfg_r.bucket_capacity <= BUCKET_CAPACITY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REFILL_RATE:     cfg_r.refill_rate     <= cfg_data[Q_W-1:0];
        REG_BUCKET_CAPACITY: cfg_r.bucket_capacity <= cfg_data[Q_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack request beat
  assign in_client = in_tdata[CLIENT_IN_W-1:0];
  assign in_now    = in_tdata[CLIENT_IN_W +: TICK_W];
  assign in_cost   = in_tdata[CLIENT_IN_W+TICK_W +: COST_W];

  pctb_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_client  (in_client),
    .req_now     (in_now),
    .req_cost    (in_cost),
    .rsp_valid   (out_tvalid),
    .rsp_ready   (out_tready),
    .rsp_allowed (out_allowed),
    .rsp_tokens  (out_tokens)
  );

  // pack verdict beat
  assign out_tdata = {{(OUT_DATA_W-TOKENS_W-1){1'b0}}, out_tokens, out_allowed};

endmodule

`default_nettype wire

// File: dv/per_client_token_bucket_unit_tb.sv
`default_nettype none

module per_client_token_bucket_unit_tb;
  import pctb_pkg::*;

  // verdict latency of the block, used to pad the waits in drain and at the end
  localparam int VERDICT_LATENCY = 4;
  // cycles without any beat on any channel before the run is declared hung
  localparam int HANG_LIMIT      = 3000;
  // length of the receiver hold-off, long enough to back the block up
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 205;
  localparam int POOL_SIZE       = 8;

  // a register index the block does not decode, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(8'hFF);

  // one verdict as the block reports it
  typedef struct packed {
    logic                allowed;
    logic [TOKENS_W-1:0] tokens_left;
  } verdict_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // one line of the directed table: a request or a register write
  typedef struct {
    row_kind_t              kind;
    logic [CLIENT_IN_W-1:0] client;
    logic [TICK_W-1:0]      now_ticks;
    logic [COST_W-1:0]      cost;
    bit                     known;     // verdict typed in by hand
    verdict_t               verdict;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  per_client_token_bucket_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // policer shadow: own copy of the bucket table and the two registers
  // ---------------------------------------------------------------------
  logic [Q_W-1:0]    shadow_rate = REFILL_RATE_RST;
  logic [Q_W-1:0]    shadow_cap  = BUCKET_CAPACITY_RST;
  bit                shadow_valid [NUM_CLIENTS];
  logic [Q_W-1:0]    shadow_level [NUM_CLIENTS];
  logic [TICK_W-1:0] shadow_last  [NUM_CLIENTS];

  // verdicts still owed by the block, oldest first
  verdict_t pending_verdicts [$];

  int errors = 0;

  // refill, clip, debit; updates the shadow bucket like the block does
  function automatic verdict_t police(input logic [CLIENT_IN_W-1:0] client,
                                      input logic [TICK_W-1:0] now_ticks,
                                      input logic [COST_W-1:0] cost);
    int                slot;
    logic [63:0]       lvl;
    logic [63:0]       need;
    logic [TICK_W-1:0] elapsed;
    verdict_t          v;
    slot = int'(client) % NUM_CLIENTS;
    need = {32'd0, cost, 16'd0};
    if (!shadow_valid[slot]) begin
      // first request since reset: bucket starts full
      shadow_valid[slot] = 1'b1;
      lvl = {32'd0, shadow_cap};
    end else begin
      // elapsed wraps modulo 2^32, product kept at full width
      elapsed = now_ticks - shadow_last[slot];
      lvl = {32'd0, shadow_level[slot]} + ({32'd0, elapsed} * {32'd0, shadow_rate});
      if (lvl > {32'd0, shadow_cap}) lvl = {32'd0, shadow_cap};
    end
    shadow_last[slot] = now_ticks;
    v.allowed = (lvl >= need);
    if (v.allowed) lvl = lvl - need;
    shadow_level[slot] = lvl[Q_W-1:0];
    v.tokens_left = lvl[FRAC_W +: TOKENS_W];
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // receiver: random back-pressure, quiet stretches and one long hold-off
  // ---------------------------------------------------------------------
  bit calm        = 1'b0;   // no idling on either side while set
  int hold_asked  = 0;      // bumped by the stimulus to ask for a hold-off
  int hold_seen   = 0;
  int hold_left   = 0;

  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen  <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 35);
    end
  end

  // ---------------------------------------------------------------------
  // verdict checker: every out beat against the oldest pending verdict
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict beat with nothing pending, got tdata %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[0] !== want.allowed) begin
          $display("%0t: allowed mismatch, expected %0b got %0b",
                   $time, want.allowed, out_tdata[0]);
          errors++;
        end
        if (out_tdata[TOKENS_W:1] !== want.tokens_left) begin
          $display("%0t: tokens_left mismatch, expected %0d got %0d",
                   $time, want.tokens_left, out_tdata[TOKENS_W:1]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // hang watchdog: counts cycles with no beat on any channel
  // ---------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d verdicts pending",
               $time, HANG_LIMIT, pending_verdicts.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // drivers, all called at a rising edge
  // ---------------------------------------------------------------------

  // offer one request and return at the edge where it is taken;
  // valid stays high so a following request goes out back to back
  task automatic send_request(input logic [CLIENT_IN_W-1:0] client,
                              input logic [TICK_W-1:0] now_ticks,
                              input logic [COST_W-1:0] cost,
                              input verdict_t verdict);
    if (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    // pushed on offer: config never moves while a request is in flight
    pending_verdicts.push_back(verdict);
    in_tvalid <= 1'b1;
    in_tdata  <= {cost, now_ticks, client};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // drop valid and let the block run dry
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (VERDICT_LATENCY + 2) @(posedge clk);
  endtask

  // register write, only once the block has gone idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_REFILL_RATE)
      shadow_rate = data;
    else if (idx == REG_BUCKET_CAPACITY)
      shadow_cap = data;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // directed table builders
  // ---------------------------------------------------------------------
  plan_row_t plan [$];

  task automatic plan_req(input logic [CLIENT_IN_W-1:0] client,
                          input logic [TICK_W-1:0] now_ticks,
                          input logic [COST_W-1:0] cost);
    plan_row_t r;
    r.kind      = ROW_REQ;
    r.client    = client;
    r.now_ticks = now_ticks;
    r.cost      = cost;
    r.known     = 1'b0;
    r.verdict   = '0;
    r.reg_idx   = '0;
    r.reg_data  = '0;
    plan.push_back(r);
  endtask

  task automatic plan_req_known(input logic [CLIENT_IN_W-1:0] client,
                                input logic [TICK_W-1:0] now_ticks,
                                input logic [COST_W-1:0] cost,
                                input logic allowed,
                                input logic [TOKENS_W-1:0] tokens_left);
    plan_req(client, now_ticks, cost);
    plan[$].known = 1'b1;
    plan[$].verdict = {allowed, tokens_left};
  endtask

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r.kind      = ROW_CFG;
    r.client    = '0;
    r.now_ticks = '0;
    r.cost      = '0;
    r.known     = 1'b0;
    r.verdict   = '0;
    r.reg_idx   = idx;
    r.reg_data  = data;
    plan.push_back(r);
  endtask

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    verdict_t               v;
    logic [CLIENT_IN_W-1:0] pool [POOL_SIZE];
    logic [CLIENT_IN_W-1:0] client;
    logic [TICK_W-1:0]      t_now;
    logic [COST_W-1:0]      cost;
    int                     pick;

    // reset defaults: 1.0 token per tick, 10.0 tokens capacity
    plan_req_known(8'd0, 32'd100, 16'd0, 1'b1, 16'd10);        // new bucket starts full
    plan_req_known(8'd0, 32'd100, 16'd10, 1'b1, 16'd0);        // empties it, no time passed
    plan_req_known(8'd0, 32'd100, 16'd1, 1'b0, 16'd0);         // refused, level kept
    plan_req(8'd0, 32'd103, 16'd2);                            // three ticks of refill
    plan_req_known(8'd255, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 16'd10);
    plan_req(8'd255, 32'd5, 16'd3);                            // timestamp wraps past zero
    plan_req(8'd0, 32'd50, 16'd4);                             // time runs backwards
    plan_req_known(8'hAA, 32'hAAAA_AAAA, 16'hAAAA, 1'b0, 16'd10);
    plan_req_known(8'h55, 32'h5555_5555, 16'h5555, 1'b0, 16'd10);
    // both registers at their top values
    plan_cfg(REG_REFILL_RATE, 32'hFFFF_FFFF);
    plan_cfg(REG_BUCKET_CAPACITY, 32'hFFFF_FFFF);
    plan_req_known(8'd1, 32'd0, 16'hFFFF, 1'b1, 16'd0);        // largest cost fits
    plan_req(8'd1, 32'd1, 16'hFFFF);                           // one tick at the top refill rate
    plan_req(8'hAA, 32'hAAAA_AAAB, 16'hAAAA);
    // no refill, capacity well below what client 0 holds
    plan_cfg(REG_REFILL_RATE, 32'd0);
    plan_cfg(REG_BUCKET_CAPACITY, 32'd2 << FRAC_W);
    plan_req(8'd0, 32'd60, 16'd0);                             // zero cost, clipped down
    plan_req(8'd0, 32'd1000, 16'd1);
    plan_cfg(REG_SPARE, 32'd0);                                // unknown index, dropped
    plan_req(8'd0, 32'd2000, 16'd1);
    plan_cfg(REG_BUCKET_CAPACITY, 32'd0);
    plan_req_known(8'd3, 32'd7, 16'd0, 1'b1, 16'd0);           // empty new bucket, zero cost
    plan_req_known(8'd3, 32'd8, 16'd1, 1'b0, 16'd0);
    plan_cfg(REG_REFILL_RATE, 32'h0000_8000);                  // half a token per tick
    plan_cfg(REG_BUCKET_CAPACITY, BUCKET_CAPACITY_RST);
    plan_req(8'd3, 32'd12, 16'd1);
    plan_req(8'd3, 32'd13, 16'd1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        v = police(plan[i].client, plan[i].now_ticks, plan[i].cost);
        if (plan[i].known) v = plan[i].verdict;
        send_request(plan[i].client, plan[i].now_ticks, plan[i].cost, v);
      end
    end

    // random part: one register setting per phase, a small pool of busy
    // clients so buckets are revisited, time mostly creeping forward
    t_now = $urandom();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_REFILL_RATE, REFILL_RATE_RST);
          write_reg(REG_BUCKET_CAPACITY, BUCKET_CAPACITY_RST);
        end
        1: begin
          write_reg(REG_REFILL_RATE, 32'hFFFF_FFFF);
          write_reg(REG_BUCKET_CAPACITY, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(REG_REFILL_RATE, 32'd0);
          write_reg(REG_BUCKET_CAPACITY, $urandom());
        end
        3: begin
          write_reg(REG_REFILL_RATE, $urandom_range(1, 32'h0004_0000));
          write_reg(REG_BUCKET_CAPACITY, $urandom_range(32'h0001_0000, 32'h0028_0000));
        end
        4: begin
          write_reg(REG_REFILL_RATE, $urandom());
          write_reg(REG_BUCKET_CAPACITY, 32'd0);
        end
        5: begin
          write_reg(REG_REFILL_RATE, 32'h0000_8000);
          write_reg(REG_BUCKET_CAPACITY, 32'd5 << FRAC_W);
        end
        6: begin
          write_reg(REG_REFILL_RATE, $urandom());
          write_reg(REG_BUCKET_CAPACITY, $urandom());
        end
        default: begin
          write_reg(REG_REFILL_RATE, 32'h0000_1000);
          write_reg(REG_BUCKET_CAPACITY, 32'd20 << FRAC_W);
        end
      endcase

      foreach (pool[j]) pool[j] = CLIENT_IN_W'($urandom_range(255));
      // phase 3 runs with no idling on either side
      calm <= (ph == 3);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // receiver holds off while requests keep coming
        if (ph == 2 && k == 50) hold_asked <= hold_asked + 1;
        // sender pauses until the block has answered everything
        if (ph == 5 && k == 100) drain();

        pick = $urandom_range(99);
        client = (pick < 85) ? pool[$urandom_range(POOL_SIZE - 1)]
                             : CLIENT_IN_W'($urandom_range(255));

        pick = $urandom_range(99);
        if (pick < 15)      t_now = t_now;
        else if (pick < 85) t_now = t_now + $urandom_range(1, 8);
        else if (pick < 95) t_now = t_now + $urandom_range(0, 1000);
        else                t_now = $urandom();   // jump, often backwards

        pick = $urandom_range(99);
        if (pick < 10)      cost = '0;
        else if (pick < 55) cost = COST_W'($urandom_range(1, 4));
        else if (pick < 85) cost = COST_W'($urandom_range(0, 20));
        else                cost = COST_W'($urandom_range(16'hFFFF));

        v = police(client, t_now, cost);
        send_request(client, t_now, cost, v);
      end
    end

    calm <= 1'b0;
    drain();
    repeat (4 * VERDICT_LATENCY) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
